// File: rtl/fwpe_pkg.sv
// Shared types, codes and default sizes for the priority-extract queue.
// No dependencies; used by every module under rtl/ except fwpe_ram.
`default_nettype none

package fwpe_pkg;

   // default sizes
   localparam int DEPTH_DEFAULT      = 16;
   localparam int TAG_WIDTH_DEFAULT  = 16;
   localparam int PRIO_WIDTH_DEFAULT = 8;

   // fixed field widths
   localparam int ACT_WIDTH    = 2;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 5;

   // action codes
   localparam logic [ACT_WIDTH-1:0] ACT_PUSH    = 2'd0;
   localparam logic [ACT_WIDTH-1:0] ACT_POP     = 2'd1;
   localparam logic [ACT_WIDTH-1:0] ACT_EXTRACT = 2'd2;

   // status codes
   localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic load_item;    // latch the accepted request beat
      logic set_full;
      logic set_empty;
      logic push_write;   // write item at tail, count up
      logic scan_start;
      logic shift_start;
      logic run;          // step the read/compare/move pipe
      logic head_adv;
      logic count_dec;
      logic load_rsp;     // load the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [ACT_WIDTH-1:0] act;
      logic                 empty;
      logic                 full;
      logic                 scan_done;
      logic                 shift_done;
      logic                 best_head;
      logic                 best_tail;
      logic                 out_free;
   } sts_type;

endpackage

`default_nettype wire

// File: rtl/fwpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fwpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/fwpe_datapath.sv
// Datapath: circular entry store, scan/compare pipe, gap-close mover and
// output register. Depends on fwpe_pkg and fwpe_ram.
`default_nettype none

module fwpe_datapath #(
   parameter int DEPTH      = fwpe_pkg::DEPTH_DEFAULT,
   parameter int TAG_WIDTH  = fwpe_pkg::TAG_WIDTH_DEFAULT,
   parameter int PRIO_WIDTH = fwpe_pkg::PRIO_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire fwpe_pkg::cmd_type                   cmd,
   output fwpe_pkg::sts_type                        sts,
   input  wire logic [fwpe_pkg::ACT_WIDTH-1:0]      req_act,
   input  wire logic [TAG_WIDTH-1:0]                req_tag,
   input  wire logic [PRIO_WIDTH-1:0]               req_prio,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [fwpe_pkg::STATUS_WIDTH-1:0]   rsp_status,
   output logic      [TAG_WIDTH-1:0]                rsp_tag,
   output logic      [PRIO_WIDTH-1:0]               rsp_prio,
   output logic      [fwpe_pkg::COUNT_WIDTH-1:0]    rsp_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int RW = TAG_WIDTH + PRIO_WIDTH;

   // control state
   logic [AW-1:0]                     head_ff, head_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [CW-1:0]                     idx_ff, idx_in;
   logic                              rd_vld_ff, rd_vld_in;
   logic                              shift_mode_ff, shift_mode_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   // payload
   logic [fwpe_pkg::ACT_WIDTH-1:0]    act_ff, act_in;
   logic [TAG_WIDTH-1:0]              tag_ff, tag_in;
   logic [PRIO_WIDTH-1:0]             prio_ff, prio_in;
   logic [CW-1:0]                     rd_idx_ff, rd_idx_in;
   logic [CW-1:0]                     best_idx_ff, best_idx_in;
   logic [TAG_WIDTH-1:0]              best_tag_ff, best_tag_in;
   logic [PRIO_WIDTH-1:0]             best_prio_ff, best_prio_in;
   logic [fwpe_pkg::STATUS_WIDTH-1:0] status_ff, status_in;
   logic [fwpe_pkg::STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic [TAG_WIDTH-1:0]              rsp_tag_ff, rsp_tag_in;
   logic [PRIO_WIDTH-1:0]             rsp_prio_ff, rsp_prio_in;
   logic [fwpe_pkg::COUNT_WIDTH-1:0]  rsp_count_ff, rsp_count_in;

   // RAM side
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [RW-1:0] ram_wdata, ram_rdata;
   logic [CW:0]   rd_sum, wr_sum;
   logic [CW-1:0] wr_logical;
   logic [CW-1:0] limit;
   logic [TAG_WIDTH-1:0]  q_tag;
   logic [PRIO_WIDTH-1:0] q_prio;

   assign q_tag  = ram_rdata[RW-1:PRIO_WIDTH];
   assign q_prio = ram_rdata[PRIO_WIDTH-1:0];

   // pop looks at the head only, extract and gap close walk to the tail
   assign limit = (!shift_mode_ff && act_ff == fwpe_pkg::ACT_POP) ? CW'(1) : count_ff;

   // logical -> physical, sum stays below 2*DEPTH
   always_comb begin
      rd_sum = (CW+1)'(head_ff) + (CW+1)'(idx_ff);
      if (rd_sum >= (CW+1)'(DEPTH)) begin
         rd_sum = rd_sum - (CW+1)'(DEPTH);
      end
      wr_logical = shift_mode_ff ? (rd_idx_ff - CW'(1)) : count_ff;
      wr_sum = (CW+1)'(head_ff) + (CW+1)'(wr_logical);
      if (wr_sum >= (CW+1)'(DEPTH)) begin
         wr_sum = wr_sum - (CW+1)'(DEPTH);
      end
   end

   assign ram_raddr = rd_sum[AW-1:0];
   assign ram_waddr = wr_sum[AW-1:0];

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rd_vld_in     = rd_vld_ff;
      shift_mode_in = shift_mode_ff;
      act_in        = act_ff;
      tag_in        = tag_ff;
      prio_in       = prio_ff;
      rd_idx_in     = rd_idx_ff;
      best_idx_in   = best_idx_ff;
      best_tag_in   = best_tag_ff;
      best_prio_in  = best_prio_ff;
      status_in     = status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ram_we        = 1'b0;
      ram_wdata     = {tag_ff, prio_ff};

      if (cmd.load_item) begin
         act_in        = req_act;
         tag_in        = req_tag;
         prio_in       = req_prio;
         status_in     = fwpe_pkg::ST_OK;
         best_tag_in   = '0;
         best_prio_in  = '0;
         // push writes land at the tail, not at the last gap-close slot
         shift_mode_in = 1'b0;
      end
      if (cmd.set_full) begin
         status_in = fwpe_pkg::ST_FULL;
      end
      if (cmd.set_empty) begin
         status_in = fwpe_pkg::ST_EMPTY;
      end
      if (cmd.push_write) begin
         ram_we   = 1'b1;
         count_in = count_ff + CW'(1);
      end
      if (cmd.scan_start) begin
         idx_in        = '0;
         rd_vld_in     = 1'b0;
         shift_mode_in = 1'b0;
      end
      if (cmd.shift_start) begin
         idx_in        = best_idx_ff + CW'(1);
         rd_vld_in     = 1'b0;
         shift_mode_in = 1'b1;
      end
      if (cmd.run) begin
         // issue side
         if (idx_ff < limit) begin
            idx_in    = idx_ff + CW'(1);
            rd_vld_in = 1'b1;
            rd_idx_in = idx_ff;
         end else begin
            rd_vld_in = 1'b0;
         end
         // data side, on the registered read data
         if (rd_vld_ff) begin
            if (shift_mode_ff) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata;
            end else if (rd_idx_ff == '0 || q_prio < best_prio_ff) begin
               // strict less keeps the earliest of equal priorities
               best_idx_in  = rd_idx_ff;
               best_tag_in  = q_tag;
               best_prio_in = q_prio;
            end
         end
      end
      if (cmd.head_adv) begin
         head_in = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
      end
      if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_tag_in    = best_tag_ff;
         rsp_prio_in   = best_prio_ff;
         rsp_count_in  = fwpe_pkg::COUNT_WIDTH'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         idx_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         shift_mode_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         rd_vld_ff     <= rd_vld_in;
         shift_mode_ff <= shift_mode_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      tag_ff        <= tag_in;
      prio_ff       <= prio_in;
      rd_idx_ff     <= rd_idx_in;
      best_idx_ff   <= best_idx_in;
      best_tag_ff   <= best_tag_in;
      best_prio_ff  <= best_prio_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_count_ff  <= rsp_count_in;
   end

   fwpe_ram #(
      .WIDTH (RW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      sts.act        = act_ff;
      sts.empty      = (count_ff == '0);
      sts.full       = (count_ff == CW'(DEPTH));
      sts.scan_done  = rd_vld_ff && !shift_mode_ff && (rd_idx_ff == limit - CW'(1));
      sts.shift_done = rd_vld_ff && shift_mode_ff && (rd_idx_ff == count_ff - CW'(1));
      sts.best_head  = (best_idx_ff == '0);
      sts.best_tail  = (best_idx_ff == count_ff - CW'(1));
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_tag    = rsp_tag_ff;
   assign rsp_prio   = rsp_prio_ff;
   assign rsp_count  = rsp_count_ff;

   // full status only reported on a full store
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp && status_ff == fwpe_pkg::ST_FULL) |-> count_ff == CW'(DEPTH))
      else $error("full status with room left");

   // empty status only reported on an empty store
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp && status_ff == fwpe_pkg::ST_EMPTY) |-> count_ff == '0)
      else $error("empty status with entries held");

   // accepted push grows the store by one
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      cmd.push_write |=> count_ff == $past(count_ff) + CW'(1))
      else $error("push did not advance count");

   // gap-close writes never land on the slot being read
   a_move_addr: assert property (@(posedge clock) disable iff (reset)
      (cmd.run && shift_mode_ff && rd_vld_ff && idx_ff < count_ff) |-> ram_waddr != ram_raddr)
      else $error("move write collides with read");

endmodule

`default_nettype wire

// File: rtl/fwpe_controller.sv
// Controller state machine: sequences push, scan, removal and result load.
// Depends on fwpe_pkg; drives fwpe_datapath through cmd/sts structs.
`default_nettype none

module fwpe_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire fwpe_pkg::sts_type sts,
   output fwpe_pkg::cmd_type      cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_REMOVE = 3'd3;
   localparam logic [2:0] S_SHIFT  = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.act) inside
               fwpe_pkg::ACT_PUSH: begin
                  if (sts.full) begin
                     cmd.set_full = 1'b1;
                  end else begin
                     cmd.push_write = 1'b1;
                  end
                  state_in = S_FINISH;
               end
               fwpe_pkg::ACT_POP, fwpe_pkg::ACT_EXTRACT: begin
                  if (sts.empty) begin
                     cmd.set_empty = 1'b1;
                     state_in      = S_FINISH;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SCAN: begin
            cmd.run = 1'b1;
            if (sts.scan_done) begin
               state_in = S_REMOVE;
            end
         end
         S_REMOVE: begin
            if (sts.best_head) begin
               cmd.head_adv  = 1'b1;
               cmd.count_dec = 1'b1;
               state_in      = S_FINISH;
            end else if (sts.best_tail) begin
               cmd.count_dec = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.shift_start = 1'b1;
               state_in        = S_SHIFT;
            end
         end
         S_SHIFT: begin
            cmd.run = 1'b1;
            if (sts.shift_done) begin
               cmd.count_dec = 1'b1;
               state_in      = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // one request beat in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second beat taken while busy");

   // result loads only from the finish step, never twice back to back
   a_single_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> !cmd.load_rsp)
      else $error("result loaded twice");

endmodule

`default_nettype wire

// File: rtl/fifo_with_priority_extract_unit.sv
// Top level of the ordered queue with lowest-priority extraction.
// Depends on fwpe_pkg, fwpe_controller, fwpe_datapath (and fwpe_ram below it).
`default_nettype none

// Ordered queue of up to DEPTH entries (tag, priority), one request beat in,
// one result beat out for every request. req_tuser selects the action: push
// at tail, pop head, or extract the lowest priority value (earliest wins on a
// tie, survivors keep their order). The result carries status in rsp_tuser
// and the removed tag, priority (zero if nothing removed) and the count after
// the step in rsp_tdata. Push to a full queue gives the full status, removal
// from an empty queue the empty status, action code 3 is a no-op with ok.
// Entries live in a single-port-read RAM laid out as a ring from a head
// pointer. One request is worked at a time; the result sits in an output
// register, so the next request beat is taken while the result waits.
// Push, refused push, empty removal and the no-op need no RAM read;
// pop reads the head entry only; extract scans every entry held and,
// when the minimum sits between head and tail, closes the gap by
// moving each entry behind it one place toward the head. Scan and gap
// close make one RAM read per cycle.
// No clearing pass after reset: entry storage is read only once written.

module fifo_with_priority_extract_unit #(
   parameter int DEPTH      = fwpe_pkg::DEPTH_DEFAULT,
   parameter int TAG_WIDTH  = fwpe_pkg::TAG_WIDTH_DEFAULT,
   parameter int PRIO_WIDTH = fwpe_pkg::PRIO_WIDTH_DEFAULT,
   localparam int REQ_DW    = ((TAG_WIDTH + PRIO_WIDTH + 7) / 8) * 8,
   localparam int RSP_DW    =
      ((TAG_WIDTH + PRIO_WIDTH + fwpe_pkg::COUNT_WIDTH + 7) / 8) * 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [REQ_DW-1:0]                 req_tdata,  // item_tag, item_priority
   input  wire logic [fwpe_pkg::ACT_WIDTH-1:0]    req_tuser,  // action
   // result channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [RSP_DW-1:0]                 rsp_tdata,  // result_tag, result_priority,
                                                              // entry_count
   output logic      [fwpe_pkg::STATUS_WIDTH-1:0] rsp_tuser   // status
);

   fwpe_pkg::cmd_type cmd;
   fwpe_pkg::sts_type sts;

   logic [TAG_WIDTH-1:0]              rsp_tag;
   logic [PRIO_WIDTH-1:0]             rsp_prio;
   logic [fwpe_pkg::COUNT_WIDTH-1:0]  rsp_count;

   fwpe_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   fwpe_datapath #(
      .DEPTH      (DEPTH),
      .TAG_WIDTH  (TAG_WIDTH),
      .PRIO_WIDTH (PRIO_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_act    (req_tuser),
      .req_tag    (req_tdata[TAG_WIDTH-1:0]),
      .req_prio   (req_tdata[TAG_WIDTH+PRIO_WIDTH-1:TAG_WIDTH]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_tag    (rsp_tag),
      .rsp_prio   (rsp_prio),
      .rsp_count  (rsp_count)
   );

   // pack low to high, zero fill to whole bytes
   assign rsp_tdata = RSP_DW'({rsp_count, rsp_prio, rsp_tag});

endmodule

`default_nettype wire

// File: bench/tb_fifo_with_priority_extract_unit.sv
// Self-checking bench for fifo_with_priority_extract_unit: stream beats in, results
// checked against an in-bench queue model. Needs rtl/fwpe_pkg.sv and the unit's RTL.
`timescale 1ns / 100ps

module tb_fifo_with_priority_extract_unit;

   localparam int DEPTH       = fwpe_pkg::DEPTH_DEFAULT;
   localparam int TAG_W       = fwpe_pkg::TAG_WIDTH_DEFAULT;
   localparam int PRIO_W      = fwpe_pkg::PRIO_WIDTH_DEFAULT;
   localparam int ACT_W       = fwpe_pkg::ACT_WIDTH;
   localparam int STAT_W      = fwpe_pkg::STATUS_WIDTH;
   localparam int CNT_W       = fwpe_pkg::COUNT_WIDTH;
   localparam int REQ_DW      = ((TAG_W + PRIO_W + 7) / 8) * 8;
   localparam int RSP_DW      = ((TAG_W + PRIO_W + CNT_W + 7) / 8) * 8;
   localparam int RSP_USED    = TAG_W + PRIO_W + CNT_W;
   localparam int IDLE_PCT    = 24;
   // settle wait covers the worst-case beat; give it some margin
   localparam int SETTLE_CYC  = 2 * DEPTH + 10;
   localparam int CYCLE_LIMIT = 1_000_000;

   // the unused action code; the unit treats it as a no-op
   localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
   } slot_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
      logic [CNT_W-1:0]  count;
   } reply_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DW-1:0]       req_tdata  = '0;   // item_tag, item_priority
   logic [ACT_W-1:0]        req_tuser  = '0;   // action
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DW-1:0]       rsp_tdata;         // result_tag, result_priority, entry_count
   logic [STAT_W-1:0]       rsp_tuser;         // status

   // shadow copy of the queue contents, head at index 0
   slot_type  shadow_slots[$];
   // replies owed by the unit, oldest first
   reply_type replies_owed[$];

   // idle knobs, flipped by the tests
   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   // hold-off request to the ready driver: bump the serial, it counts the cycles itself
   int hold_serial = 0;
   int hold_length = 0;

   int cycle_count    = 0;
   int mismatch_count = 0;
   int beats_taken    = 0;
   int replies_seen   = 0;
   int full_refusals  = 0;
   int empty_removals = 0;
   int mid_extracts   = 0;
   int peak_fill      = 0;

   fifo_with_priority_extract_unit #(
      .DEPTH      (DEPTH),
      .TAG_WIDTH  (TAG_W),
      .PRIO_WIDTH (PRIO_W)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Queue model: applies one action to the shadow queue, returns the reply due.
   // Extract picks the first entry holding the lowest priority value; the rest
   // keep their order. Code 3 leaves everything alone and answers ok.
   // ---------------------------------------------------------------------------
   function automatic reply_type apply_queue_action(input logic [ACT_W-1:0]  act,
                                                    input logic [TAG_W-1:0]  tag,
                                                    input logic [PRIO_W-1:0] prio);
      reply_type r;
      slot_type  s;
      int        pick;
      r        = '0;
      r.status = fwpe_pkg::ST_OK;
      case (act)
         fwpe_pkg::ACT_PUSH: begin
            if (shadow_slots.size() >= DEPTH) begin
               r.status = fwpe_pkg::ST_FULL;
               full_refusals++;
            end else begin
               s.tag  = tag;
               s.prio = prio;
               shadow_slots.push_back(s);
            end
         end
         fwpe_pkg::ACT_POP, fwpe_pkg::ACT_EXTRACT: begin
            if (shadow_slots.size() == 0) begin
               r.status = fwpe_pkg::ST_EMPTY;
               empty_removals++;
            end else begin
               pick = 0;
               if (act == fwpe_pkg::ACT_EXTRACT) begin
                  for (int i = 1; i < shadow_slots.size(); i++)
                     if (shadow_slots[i].prio < shadow_slots[pick].prio) pick = i;
                  if (pick != 0 && pick != shadow_slots.size() - 1) mid_extracts++;
               end
               r.tag  = shadow_slots[pick].tag;
               r.prio = shadow_slots[pick].prio;
               shadow_slots.delete(pick);
            end
         end
         default: ;
      endcase
      r.count = CNT_W'(shadow_slots.size());
      if (shadow_slots.size() > peak_fill) peak_fill = shadow_slots.size();
      return r;
   endfunction

   // Every accepted request beat is run through the model at the edge that takes it.
   // The reply to that beat is never valid on that same edge.
   always @(posedge clock) begin : track_requests
      if (!reset && req_tvalid && req_tready) begin
         replies_owed.push_back(apply_queue_action(req_tuser, req_tdata[TAG_W-1:0],
                                                   req_tdata[TAG_W +: PRIO_W]));
         beats_taken++;
      end
   end

   task automatic report_mismatch(input string what, input longint got_v,
                                  input longint want_v);
      $display("%0t ns: reply %0d %s mismatch: got 0x%0h, want 0x%0h",
               $time, replies_seen, what, got_v, want_v);
      mismatch_count++;
   endtask

   // Result side: each accepted reply beat is compared against the oldest one owed.
   always @(posedge clock) begin : check_replies
      reply_type got;
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser;
         got.tag    = rsp_tdata[TAG_W-1:0];
         got.prio   = rsp_tdata[TAG_W +: PRIO_W];
         got.count  = rsp_tdata[TAG_W + PRIO_W +: CNT_W];
         if (replies_owed.size() == 0) begin
            report_mismatch("unsolicited beat", rsp_tdata, 0);
         end else begin
            want = replies_owed.pop_front();
            if (got.status !== want.status) report_mismatch("status", got.status, want.status);
            if (got.tag !== want.tag)       report_mismatch("tag", got.tag, want.tag);
            if (got.prio !== want.prio)     report_mismatch("priority", got.prio, want.prio);
            if (got.count !== want.count)   report_mismatch("count", got.count, want.count);
         end
         // pad bits above the count must read zero
         if (RSP_DW > RSP_USED && rsp_tdata[RSP_DW-1:RSP_USED] !== '0)
            report_mismatch("pad bits", rsp_tdata[RSP_DW-1:RSP_USED], 0);
         replies_seen++;
      end
   end

   // Result ready: random stalls, or a counted hold-off when a test asks for one.
   always @(posedge clock) begin : drive_rsp_ready
      int hold_seen;
      int hold_left;
      if (hold_serial != hold_seen) begin
         hold_seen = hold_serial;
         hold_left = hold_length;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (receiver_idles) begin
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offers one request beat and returns at the edge that takes it. Valid stays
   // high into the next offer unless an idle gap is rolled first.
   task automatic offer_request(input logic [ACT_W-1:0]  act,
                                input logic [TAG_W-1:0]  tag,
                                input logic [PRIO_W-1:0] prio);
      while (sender_idles && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= REQ_DW'({prio, tag});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Sender pause: drop valid, let every owed reply come back, then let the unit settle.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (replies_owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // Random well-formed traffic. Bursts lean toward filling, mixing or draining
   // so the fill level sweeps the whole range; low priorities come from a narrow
   // band half the time so ties are common.
   task automatic random_requests(input int n_beats);
      int                  burst_left;
      int                  push_pct;
      int                  roll;
      logic [ACT_W-1:0]    act;
      logic [PRIO_W-1:0]   prio;
      burst_left = 0;
      push_pct   = 50;
      for (int n = 0; n < n_beats; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
               0:       push_pct = 80;
               1:       push_pct = 50;
               default: push_pct = 20;
            endcase
         end
         burst_left--;
         roll = $urandom_range(0, 99);
         if (roll < 3)                        act = ACT_NOP;
         else if (roll < push_pct)            act = fwpe_pkg::ACT_PUSH;
         else if ($urandom_range(0, 99) < 35) act = fwpe_pkg::ACT_POP;
         else                                 act = fwpe_pkg::ACT_EXTRACT;
         prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
         offer_request(act, TAG_W'($urandom), prio);
      end
   endtask

   // Removal and no-op on an empty queue right after reset.
   task automatic test_empty_queue();
      offer_request(fwpe_pkg::ACT_POP, '0, '0);
      offer_request(fwpe_pkg::ACT_EXTRACT, '1, '1);
      offer_request(ACT_NOP, '1, '1);
      wait_drained();
   endtask

   // Fill to DEPTH with extreme tags and priorities, then one push too many.
   task automatic test_fill_past_full();
      logic [PRIO_W-1:0] fill_prio [16];
      logic [TAG_W-1:0]  tag;
      fill_prio = '{8'd7, 8'd200, 8'd3, 8'd255, 8'd3, 8'd9, 8'd0, 8'd128,
                    8'd0, 8'd64, 8'd17, 8'd254, 8'd1, 8'd33, 8'd2, 8'd1};
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0)              tag = '0;
         else if (i == DEPTH - 1) tag = '1;
         else                     tag = TAG_W'(16'hC000 + i);
         offer_request(fwpe_pkg::ACT_PUSH, tag, fill_prio[i % 16]);
      end
      offer_request(fwpe_pkg::ACT_PUSH, '1, '1);   // refused: queue full
      wait_drained();
   endtask

   // Extract from the middle with tied minima, a pop, a no-op on a full-ish queue.
   task automatic test_extract_order();
      // first of two zeros, then the second
      offer_request(fwpe_pkg::ACT_EXTRACT, TAG_W'($urandom), PRIO_W'($urandom));
      offer_request(fwpe_pkg::ACT_EXTRACT, TAG_W'($urandom), PRIO_W'($urandom));
      offer_request(fwpe_pkg::ACT_POP, TAG_W'($urandom), PRIO_W'($urandom));
      offer_request(ACT_NOP, TAG_W'($urandom), PRIO_W'($urandom));
      // earlier of the ones
      offer_request(fwpe_pkg::ACT_EXTRACT, TAG_W'($urandom), PRIO_W'($urandom));
      wait_drained();
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering, so
   // the output register fills and the unit stalls its request side.
   task automatic test_output_hold_off();
      hold_length = 300;
      hold_serial++;
      random_requests(24);
      wait_drained();
   endtask

   // Long stretch with both sides always ready.
   task automatic test_back_to_back();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      random_requests(300);
      wait_drained();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // Bulk of the run: random idling on both sides, one more hold-off midway.
   task automatic test_random_mix();
      random_requests(600);
      hold_length = 150;
      hold_serial++;
      random_requests(650);
      wait_drained();
   endtask

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[fifo_with_priority_extract_unit] ERROR");
      $finish;
   end

   initial begin : run_tests
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_fill_past_full();
      test_extract_order();
      test_output_hold_off();
      test_back_to_back();
      test_random_mix();
      $display("Covered %0d request beats and %0d replies in %0d cycles; peak fill %0d.",
               beats_taken, replies_seen, cycle_count, peak_fill);
      $display("Refused pushes %0d, removals from empty %0d, mid-queue extracts %0d.",
               full_refusals, empty_removals, mid_extracts);
      if (mismatch_count == 0) begin
         $display("[fifo_with_priority_extract_unit] OK");
      end else begin
         $display("[fifo_with_priority_extract_unit] ERROR");
      end
      $finish;
   end

endmodule
